// File: design/ipv4_header_checker_assert.svh
// Assertion macros shared by the IPv4 header checker's checker module.
`ifndef IPV4_HEADER_CHECKER_ASSERT_SVH
`define IPV4_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4_header_checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4_header_checker assertion failed");

`endif

// File: design/ihc_pkg.sv
// Types and constants for the IPv4 header checker.
`default_nettype none

package ihc_pkg;

    typedef enum logic [1:0] {
        STATUS_VALID        = 2'd0,
        STATUS_BAD_VERSION  = 2'd1,
        STATUS_BAD_CHECKSUM = 2'd2,
        STATUS_SHORT_HEADER = 2'd3
    } status_t;

    localparam logic [3:0] IP_VERSION       = 4'd4;
    localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

    // Byte positions inside the header
    localparam logic [5:0] IDX_TOS      = 6'd1;
    localparam logic [5:0] IDX_TLEN_HI  = 6'd2;
    localparam logic [5:0] IDX_TLEN_LO  = 6'd3;
    localparam logic [5:0] IDX_ID_HI    = 6'd4;
    localparam logic [5:0] IDX_ID_LO    = 6'd5;
    localparam logic [5:0] IDX_FF_HI    = 6'd6;
    localparam logic [5:0] IDX_FF_LO    = 6'd7;
    localparam logic [5:0] IDX_TTL      = 6'd8;
    localparam logic [5:0] IDX_PROTO    = 6'd9;
    localparam logic [5:0] IDX_SRC_0    = 6'd12;
    localparam logic [5:0] IDX_SRC_1    = 6'd13;
    localparam logic [5:0] IDX_SRC_2    = 6'd14;
    localparam logic [5:0] IDX_SRC_3    = 6'd15;
    localparam logic [5:0] IDX_DST_0    = 6'd16;
    localparam logic [5:0] IDX_DST_1    = 6'd17;
    localparam logic [5:0] IDX_DST_2    = 6'd18;
    localparam logic [5:0] IDX_DST_3    = 6'd19;

    localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;
    localparam logic [15:0] SUM_ALL_ONES    = 16'hffff;
    localparam logic [15:0] SUM_ZERO        = 16'h0000;

endpackage

`default_nettype wire

// File: design/ihc_stream_if.sv
// Valid/ready channel interfaces: header bytes in, check results out.
`default_nettype none

interface ihc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_packet;

    modport source (output valid, output data_byte, output start_of_packet, input ready);
    modport sink   (input valid, input data_byte, input start_of_packet, output ready);
endinterface

interface ihc_out_if;
    logic                  valid;
    logic                  ready;
    ihc_pkg::status_t      status;
    logic [5:0]            header_bytes;
    logic [7:0]            type_of_service;
    logic [15:0]           total_length;
    logic [15:0]           identification;
    logic [15:0]           flags_fragment;
    logic [7:0]            time_to_live;
    logic [7:0]            protocol_number;
    logic [31:0]           source_addr;
    logic [31:0]           dest_addr;
    logic [15:0]           computed_checksum;

    modport source (
        output valid, output status, output header_bytes, output type_of_service,
        output total_length, output identification, output flags_fragment,
        output time_to_live, output protocol_number, output source_addr,
        output dest_addr, output computed_checksum, input ready
    );
    modport sink (
        input valid, input status, input header_bytes, input type_of_service,
        input total_length, input identification, input flags_fragment,
        input time_to_live, input protocol_number, input source_addr,
        input dest_addr, input computed_checksum, output ready
    );
endinterface

`default_nettype wire

// File: design/ipv4_header_checker.sv
// IPv4 header checker: parses header bytes, checks version and checksum, reports fields.
//
// Takes one packet byte per cycle; a byte with start_of_packet set opens a new header
// (a start inside an open header drops it without a result). Bytes go through an input
// register, then field capture and 16-bit end-around-carry add into the result register,
// so a result is reported after the last header byte is taken, or after byte 0 when
// the length nibble is below five. Throughput is one byte per cycle, set by the single
// add-and-fold of the running sum; the only stalls come from result backpressure,
// which holds both stages. Bytes after the header are dropped.
`default_nettype none

module ipv4_header_checker (
    input  wire            clk,
    input  wire            rst_n,
    ihc_in_if.sink         data,
    ihc_out_if.source      result
);

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_sop_reg;

    // parser state
    logic       active_reg, active_next;
    logic [5:0] byte_index_reg, byte_index_next;
    logic [3:0] length_words_reg, length_words_next;
    logic [3:0] version_reg, version_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0] high_byte_reg, high_byte_next;

    // captured fields
    logic [7:0]  tos_reg, tos_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] ff_reg, ff_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    ihc_pkg::status_t out_status_reg, out_status_next;
    logic [5:0]       out_hbytes_reg, out_hbytes_next;
    logic [7:0]       out_tos_reg, out_tos_next;
    logic [15:0]      out_tlen_reg, out_tlen_next;
    logic [15:0]      out_ident_reg, out_ident_next;
    logic [15:0]      out_ff_reg, out_ff_next;
    logic [7:0]       out_ttl_reg, out_ttl_next;
    logic [7:0]       out_proto_reg, out_proto_next;
    logic [31:0]      out_src_reg, out_src_next;
    logic [31:0]      out_dst_reg, out_dst_next;
    logic [15:0]      out_csum_reg, out_csum_next;

    logic        advance;
    logic        proc;
    logic        emit;
    logic [16:0] raw_sum;
    logic [5:0]  hdr_bytes;
    logic [5:0]  s1_hdr_bytes;

    assign advance = !out_valid_reg || result.ready;
    assign proc    = s1_valid_reg && advance;
    assign data.ready = !s1_valid_reg || advance;

    assign raw_sum      = {1'b0, sum_reg} + {1'b0, high_byte_reg, s1_byte_reg};
    assign hdr_bytes    = {length_words_reg, 2'b00};
    assign s1_hdr_bytes = {s1_byte_reg[3:0], 2'b00};

    always_comb
    begin
        s1_valid_next = data.ready ? data.valid : s1_valid_reg;

        active_next       = active_reg;
        byte_index_next   = byte_index_reg;
        length_words_next = length_words_reg;
        version_next      = version_reg;
        sum_next          = sum_reg;
        high_byte_next    = high_byte_reg;
        tos_next   = tos_reg;
        tlen_next  = tlen_reg;
        ident_next = ident_reg;
        ff_next    = ff_reg;
        ttl_next   = ttl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        emit = 1'b0;

        out_status_next = out_status_reg;
        out_hbytes_next = out_hbytes_reg;
        out_tos_next    = out_tos_reg;
        out_tlen_next   = out_tlen_reg;
        out_ident_next  = out_ident_reg;
        out_ff_next     = out_ff_reg;
        out_ttl_next    = out_ttl_reg;
        out_proto_next  = out_proto_reg;
        out_src_next    = out_src_reg;
        out_dst_next    = out_dst_reg;
        out_csum_next   = out_csum_reg;

        if (proc)
        begin
            if (s1_sop_reg)
            begin
                version_next      = s1_byte_reg[7:4];
                length_words_next = s1_byte_reg[3:0];
                sum_next          = '0;
                high_byte_next    = s1_byte_reg;
                if (s1_byte_reg[3:0] < ihc_pkg::MIN_HEADER_WORDS)
                begin
                    // short header: report at once, wait for next start
                    emit            = 1'b1;
                    active_next     = 1'b0;
                    byte_index_next = '0;
                    out_status_next = ihc_pkg::STATUS_SHORT_HEADER;
                    out_hbytes_next = s1_hdr_bytes;
                    out_tos_next    = '0;
                    out_tlen_next   = '0;
                    out_ident_next  = '0;
                    out_ff_next     = '0;
                    out_ttl_next    = '0;
                    out_proto_next  = '0;
                    out_src_next    = '0;
                    out_dst_next    = '0;
                    out_csum_next   = '0;
                end
                else
                begin
                    active_next     = 1'b1;
                    byte_index_next = 6'd1;
                end
            end
            else if (active_reg)
            begin
                case (byte_index_reg)
                    ihc_pkg::IDX_TOS:     tos_next          = s1_byte_reg;
                    ihc_pkg::IDX_TLEN_HI: tlen_next[15:8]   = s1_byte_reg;
                    ihc_pkg::IDX_TLEN_LO: tlen_next[7:0]    = s1_byte_reg;
                    ihc_pkg::IDX_ID_HI:   ident_next[15:8]  = s1_byte_reg;
                    ihc_pkg::IDX_ID_LO:   ident_next[7:0]   = s1_byte_reg;
                    ihc_pkg::IDX_FF_HI:   ff_next[15:8]     = s1_byte_reg;
                    ihc_pkg::IDX_FF_LO:   ff_next[7:0]      = s1_byte_reg;
                    ihc_pkg::IDX_TTL:     ttl_next          = s1_byte_reg;
                    ihc_pkg::IDX_PROTO:   proto_next        = s1_byte_reg;
                    ihc_pkg::IDX_SRC_0:   src_next[31:24]   = s1_byte_reg;
                    ihc_pkg::IDX_SRC_1:   src_next[23:16]   = s1_byte_reg;
                    ihc_pkg::IDX_SRC_2:   src_next[15:8]    = s1_byte_reg;
                    ihc_pkg::IDX_SRC_3:   src_next[7:0]     = s1_byte_reg;
                    ihc_pkg::IDX_DST_0:   dst_next[31:24]   = s1_byte_reg;
                    ihc_pkg::IDX_DST_1:   dst_next[23:16]   = s1_byte_reg;
                    ihc_pkg::IDX_DST_2:   dst_next[15:8]    = s1_byte_reg;
                    ihc_pkg::IDX_DST_3:   dst_next[7:0]     = s1_byte_reg;
                    default: ;
                endcase

                if (!byte_index_reg[0])
                    high_byte_next = s1_byte_reg;
                else if (raw_sum[16])
                    sum_next = raw_sum[15:0] + 16'd1;   // end-around carry
                else
                    sum_next = raw_sum[15:0];

                if (byte_index_reg + 6'd1 == hdr_bytes)
                begin
                    emit            = 1'b1;
                    active_next     = 1'b0;
                    byte_index_next = '0;
                    if (version_reg != ihc_pkg::IP_VERSION)
                        out_status_next = ihc_pkg::STATUS_BAD_VERSION;
                    else if (sum_next != ihc_pkg::SUM_ZERO && sum_next != ihc_pkg::SUM_ALL_ONES)
                        out_status_next = ihc_pkg::STATUS_BAD_CHECKSUM;
                    else
                        out_status_next = ihc_pkg::STATUS_VALID;
                    out_hbytes_next = hdr_bytes;
                    out_tos_next    = tos_next;
                    out_tlen_next   = tlen_next;
                    out_ident_next  = ident_next;
                    out_ff_next     = ff_next;
                    out_ttl_next    = ttl_next;
                    out_proto_next  = proto_next;
                    out_src_next    = src_next;
                    out_dst_next    = dst_next;
                    out_csum_next   = ~sum_next;
                end
                else
                begin
                    byte_index_next = byte_index_reg + 6'd1;
                end
            end
        end

        out_valid_next = advance ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            active_reg       <= 1'b0;
            byte_index_reg   <= '0;
            length_words_reg <= '0;
            version_reg      <= '0;
            sum_reg          <= '0;
            high_byte_reg    <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            active_reg       <= active_next;
            byte_index_reg   <= byte_index_next;
            length_words_reg <= length_words_next;
            version_reg      <= version_next;
            sum_reg          <= sum_next;
            high_byte_reg    <= high_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data.ready)
        begin
            s1_byte_reg <= data.data_byte;
            s1_sop_reg  <= data.start_of_packet;
        end
        tos_reg   <= tos_next;
        tlen_reg  <= tlen_next;
        ident_reg <= ident_next;
        ff_reg    <= ff_next;
        ttl_reg   <= ttl_next;
        proto_reg <= proto_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        out_status_reg <= out_status_next;
        out_hbytes_reg <= out_hbytes_next;
        out_tos_reg    <= out_tos_next;
        out_tlen_reg   <= out_tlen_next;
        out_ident_reg  <= out_ident_next;
        out_ff_reg     <= out_ff_next;
        out_ttl_reg    <= out_ttl_next;
        out_proto_reg  <= out_proto_next;
        out_src_reg    <= out_src_next;
        out_dst_reg    <= out_dst_next;
        out_csum_reg   <= out_csum_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.status            = out_status_reg;
    assign result.header_bytes      = out_hbytes_reg;
    assign result.type_of_service   = out_tos_reg;
    assign result.total_length      = out_tlen_reg;
    assign result.identification    = out_ident_reg;
    assign result.flags_fragment    = out_ff_reg;
    assign result.time_to_live      = out_ttl_reg;
    assign result.protocol_number   = out_proto_reg;
    assign result.source_addr       = out_src_reg;
    assign result.dest_addr         = out_dst_reg;
    assign result.computed_checksum = out_csum_reg;

endmodule

`default_nettype wire

// File: design/ihc_checker.sv
// Port-level assertions for the IPv4 header checker, bound to the top level.
`default_nettype none

`include "ipv4_header_checker_assert.svh"

module ihc_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              out_valid,
    input wire              out_ready,
    input ihc_pkg::status_t status,
    input wire [5:0]        header_bytes,
    input wire [15:0]       total_length,
    input wire [31:0]       source_addr,
    input wire [15:0]       computed_checksum
);

    // a stalled result word stays put
    `IHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(computed_checksum) && $stable(status))

    // short header words carry only the length
    `IHC_ASSERT_NOW(a_short_fields, clk, rst_n, out_valid && status == ihc_pkg::STATUS_SHORT_HEADER, header_bytes < ihc_pkg::MIN_HEADER_BYTES && header_bytes[1:0] == 2'b00 && total_length == 16'd0 && source_addr == 32'd0 && computed_checksum == 16'd0)

    // full headers are at least five words long
    `IHC_ASSERT_NOW(a_full_length, clk, rst_n, out_valid && status != ihc_pkg::STATUS_SHORT_HEADER, header_bytes >= ihc_pkg::MIN_HEADER_BYTES && header_bytes[1:0] == 2'b00)

    // status agrees with the reported checksum
    `IHC_ASSERT_NOW(a_csum_status, clk, rst_n, out_valid && (status == ihc_pkg::STATUS_VALID || status == ihc_pkg::STATUS_BAD_CHECKSUM), (status == ihc_pkg::STATUS_VALID) == (computed_checksum == 16'h0000 || computed_checksum == 16'hffff))

endmodule

bind ipv4_header_checker ihc_checker u_ihc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .status            (result.status),
    .header_bytes      (result.header_bytes),
    .total_length      (result.total_length),
    .source_addr       (result.source_addr),
    .computed_checksum (result.computed_checksum)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the IPv4 header checker: byte stream in, header reports out.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ihc_pkg::status_t status;
        logic [5:0]  header_bytes;
        logic [7:0]  type_of_service;
        logic [15:0] total_length;
        logic [15:0] identification;
        logic [15:0] flags_fragment;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] computed_checksum;
    } header_report_t;

    typedef struct {
        logic [7:0] value;
        logic       sop;
    } link_byte_t;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int WHOLE       = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       feed_valid = 1'b0;
    logic [7:0] feed_byte = 8'h00;
    logic       feed_start = 1'b0;
    logic       take_ready = 1'b0;

    ihc_in_if  in_ch ();
    ihc_out_if out_ch ();

    assign in_ch.valid           = feed_valid;
    assign in_ch.data_byte       = feed_byte;
    assign in_ch.start_of_packet = feed_start;
    assign out_ch.ready          = take_ready;

    ipv4_header_checker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (in_ch),
        .result (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // pending bytes and pending header reports
    link_byte_t     link_q [$];
    header_report_t report_q [$];

    int  bytes_queued = 0;
    int  header_words_queued = 0;
    int  bytes_taken = 0;
    int  mismatches = 0;
    int  status_count [4] = '{0, 0, 0, 0};
    bit  calm;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (bytes_taken >= 450) && (bytes_taken < 750);

    // parser state mirrored on the bench side
    bit             hdr_open = 1'b0;
    logic [5:0]     hdr_index = '0;
    logic [3:0]     hdr_words = '0;
    logic [3:0]     hdr_version = '0;
    logic [16:0]    ones_sum = '0;
    logic [7:0]     hi_byte = '0;
    header_report_t hdr_fields = '0;

    task automatic parse_link_byte(input logic [7:0] b, input logic sop);
        header_report_t rep;
        logic [15:0]    folded;
        rep = '0;
        if (sop)
        begin
            hdr_open    = 1'b0;
            hdr_index   = '0;
            ones_sum    = '0;
            hdr_fields  = '0;
            hdr_version = b[7:4];
            hdr_words   = b[3:0];
            hi_byte     = b;
            if (hdr_words < ihc_pkg::MIN_HEADER_WORDS)
            begin
                rep.status       = ihc_pkg::STATUS_SHORT_HEADER;
                rep.header_bytes = {hdr_words, 2'b00};
                report_q.push_back(rep);
                hi_byte = '0;
            end
            else
            begin
                hdr_open  = 1'b1;
                hdr_index = 6'd1;
            end
            return;
        end
        if (!hdr_open)
            return;

        case (hdr_index)
            ihc_pkg::IDX_TOS:     hdr_fields.type_of_service       = b;
            ihc_pkg::IDX_TLEN_HI: hdr_fields.total_length[15:8]    = b;
            ihc_pkg::IDX_TLEN_LO: hdr_fields.total_length[7:0]     = b;
            ihc_pkg::IDX_ID_HI:   hdr_fields.identification[15:8]  = b;
            ihc_pkg::IDX_ID_LO:   hdr_fields.identification[7:0]   = b;
            ihc_pkg::IDX_FF_HI:   hdr_fields.flags_fragment[15:8]  = b;
            ihc_pkg::IDX_FF_LO:   hdr_fields.flags_fragment[7:0]   = b;
            ihc_pkg::IDX_TTL:     hdr_fields.time_to_live          = b;
            ihc_pkg::IDX_PROTO:   hdr_fields.protocol_number       = b;
            ihc_pkg::IDX_SRC_0:   hdr_fields.source_addr[31:24]    = b;
            ihc_pkg::IDX_SRC_1:   hdr_fields.source_addr[23:16]    = b;
            ihc_pkg::IDX_SRC_2:   hdr_fields.source_addr[15:8]     = b;
            ihc_pkg::IDX_SRC_3:   hdr_fields.source_addr[7:0]      = b;
            ihc_pkg::IDX_DST_0:   hdr_fields.dest_addr[31:24]      = b;
            ihc_pkg::IDX_DST_1:   hdr_fields.dest_addr[23:16]      = b;
            ihc_pkg::IDX_DST_2:   hdr_fields.dest_addr[15:8]       = b;
            ihc_pkg::IDX_DST_3:   hdr_fields.dest_addr[7:0]        = b;
            default:     ;
        endcase

        if (!hdr_index[0])
            hi_byte = b;
        else
        begin
            ones_sum = ones_sum + {1'b0, hi_byte, b};
            if (ones_sum[16])
                ones_sum = {1'b0, ones_sum[15:0]} + 17'd1;
        end

        if (int'(hdr_index) + 1 == int'(hdr_words) * 4)
        begin
            folded = ones_sum[15:0];
            rep = hdr_fields;
            if (hdr_version != ihc_pkg::IP_VERSION)
                rep.status = ihc_pkg::STATUS_BAD_VERSION;
            else if (folded != ihc_pkg::SUM_ZERO && folded != ihc_pkg::SUM_ALL_ONES)
                rep.status = ihc_pkg::STATUS_BAD_CHECKSUM;
            else
                rep.status = ihc_pkg::STATUS_VALID;
            rep.header_bytes      = {hdr_words, 2'b00};
            rep.computed_checksum = ~folded;
            report_q.push_back(rep);
            hdr_open  = 1'b0;
            hdr_index = '0;
        end
        else
            hdr_index = hdr_index + 6'd1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_report(input header_report_t want, input header_report_t got);
        check_field("status", want.status, got.status);
        check_field("header_bytes", want.header_bytes, got.header_bytes);
        check_field("type_of_service", want.type_of_service, got.type_of_service);
        check_field("total_length", want.total_length, got.total_length);
        check_field("identification", want.identification, got.identification);
        check_field("flags_fragment", want.flags_fragment, got.flags_fragment);
        check_field("time_to_live", want.time_to_live, got.time_to_live);
        check_field("protocol_number", want.protocol_number, got.protocol_number);
        check_field("source_addr", want.source_addr, got.source_addr);
        check_field("dest_addr", want.dest_addr, got.dest_addr);
        check_field("computed_checksum", want.computed_checksum, got.computed_checksum);
    endtask

    // driver: one word per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin : driver
        link_byte_t nxt;
        if (!rst_n)
        begin
            feed_valid <= 1'b0;
            feed_byte  <= 8'h00;
            feed_start <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                parse_link_byte(in_ch.data_byte, in_ch.start_of_packet);
                bytes_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (link_q.size() != 0 && (calm || $urandom_range(99) >= 14))
                begin
                    nxt = link_q.pop_front();
                    feed_valid <= 1'b1;
                    feed_byte  <= nxt.value;
                    feed_start <= nxt.sop;
                end
                else
                    feed_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each report with the oldest one predicted
    always @(posedge clk or negedge rst_n)
    begin : monitor
        header_report_t got;
        header_report_t want;
        if (!rst_n)
            take_ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.status            = out_ch.status;
                got.header_bytes      = out_ch.header_bytes;
                got.type_of_service   = out_ch.type_of_service;
                got.total_length      = out_ch.total_length;
                got.identification    = out_ch.identification;
                got.flags_fragment    = out_ch.flags_fragment;
                got.time_to_live      = out_ch.time_to_live;
                got.protocol_number   = out_ch.protocol_number;
                got.source_addr       = out_ch.source_addr;
                got.dest_addr         = out_ch.dest_addr;
                got.computed_checksum = out_ch.computed_checksum;
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none actual status %0d",
                             $time, got.status);
                    mismatches++;
                end
                else
                begin
                    want = report_q.pop_front();
                    compare_report(want, got);
                    status_count[want.status]++;
                end
            end
            take_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    task automatic queue_word(input logic [7:0] b, input logic sop);
        link_byte_t w;
        w.value = b;
        w.sop   = sop;
        link_q.push_back(w);
        bytes_queued++;
    endtask

    task automatic queue_noise(input int count);
        for (int i = 0; i < count; i++)
            queue_word(8'($urandom), 1'b0);
    endtask

    // Builds one header; when ihl is five or more it gets a correct checksum and may have one
    // bit flipped past byte 0. Sends the first keep bytes and then tail payload bytes.
    task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl, input int fill,
                                input bit spoil, input int keep, input int tail);
        logic [7:0]  hdr [60];
        logic [16:0] acc;
        int          n;
        int          pick;
        n = (ihl < ihc_pkg::MIN_HEADER_WORDS) ? 1 : 4 * int'(ihl);
        for (int i = 0; i < 60; i++)
        begin
            if (fill == FILL_ZERO)
                hdr[i] = 8'h00;
            else if (fill == FILL_ONES)
                hdr[i] = 8'hff;
            else
                hdr[i] = 8'($urandom);
        end
        hdr[0] = {ver, ihl};
        if (n > 1)
        begin
            hdr[10] = 8'h00;
            hdr[11] = 8'h00;
            acc = '0;
            for (int i = 0; i < n; i += 2)
            begin
                acc = acc + {1'b0, hdr[i], hdr[i + 1]};
                if (acc[16])
                    acc = {1'b0, acc[15:0]} + 17'd1;
            end
            {hdr[10], hdr[11]} = ~acc[15:0];
            if (spoil)
            begin
                pick = $urandom_range(n - 1, 1);
                hdr[pick] = hdr[pick] ^ 8'(1 << $urandom_range(7));
            end
        end
        if (keep > n)
            keep = n;
        for (int i = 0; i < keep; i++)
            queue_word(hdr[i], i == 0);
        header_words_queued += keep;
        queue_noise(tail);
    endtask

    initial
    begin : stimulus
        int         r;
        int         w;
        int         tail;
        logic [3:0] ihl;
        logic [3:0] ver;

        // directed: idle noise, short headers, extremes, each status, restart
        queue_word(8'h00, 1'b0);
        queue_word(8'hff, 1'b0);
        queue_packet(4'd4, 4'd0, FILL_RANDOM, 1'b0, WHOLE, 0);
        queue_packet(4'd15, 4'd4, FILL_RANDOM, 1'b0, WHOLE, 2);
        queue_packet(4'd0, 4'd3, FILL_RANDOM, 1'b0, WHOLE, 0);
        queue_packet(4'd4, 4'd5, FILL_ZERO, 1'b0, WHOLE, 2);
        queue_packet(4'd4, 4'd15, FILL_ONES, 1'b0, WHOLE, 3);
        queue_packet(4'd6, 4'd5, FILL_RANDOM, 1'b0, WHOLE, 0);
        queue_packet(4'd4, 4'd5, FILL_RANDOM, 1'b1, WHOLE, 0);
        queue_packet(4'd0, 4'd15, FILL_RANDOM, 1'b1, WHOLE, 0);
        queue_packet(4'd4, 4'd9, FILL_RANDOM, 1'b0, 7, 0);
        queue_packet(4'd4, 4'd5, FILL_RANDOM, 1'b0, WHOLE, 4);

        // random: mostly well-formed headers, some broken, short or cut off
        while (bytes_queued < 1300)
        begin
            r = $urandom_range(99);
            w = $urandom_range(99);
            ihl = (w < 50) ? 4'd5 : (w < 85) ? 4'($urandom_range(8, 6))
                                             : 4'($urandom_range(15, 9));
            tail = ($urandom_range(99) < 60) ? $urandom_range(6) : 0;
            if (r < 58)
                queue_packet(ihc_pkg::IP_VERSION, ihl, FILL_RANDOM, 1'b0, WHOLE, tail);
            else if (r < 70)
                queue_packet(ihc_pkg::IP_VERSION, ihl, FILL_RANDOM, 1'b1, WHOLE, tail);
            else if (r < 78)
            begin
                ver = 4'($urandom_range(14));
                if (ver >= ihc_pkg::IP_VERSION)
                    ver = ver + 4'd1;
                queue_packet(ver, ihl, FILL_RANDOM, 1'($urandom_range(1)), WHOLE, tail);
            end
            else if (r < 86)
                queue_packet(4'($urandom), 4'($urandom_range(4)), FILL_RANDOM, 1'b0,
                             WHOLE, tail);
            else if (r < 94)
                queue_packet(ihc_pkg::IP_VERSION, ihl, FILL_RANDOM, 1'b0,
                             $urandom_range(4 * int'(ihl) - 1, 1), 0);
            else
                queue_noise($urandom_range(5, 1));
        end

        while (bytes_taken != bytes_queued)
            @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes, %0d of them inside headers.", bytes_queued,
                 header_words_queued);
        $display("Reports checked: %0d valid, %0d bad version, %0d bad checksum, %0d short.",
                 status_count[ihc_pkg::STATUS_VALID],
                 status_count[ihc_pkg::STATUS_BAD_VERSION],
                 status_count[ihc_pkg::STATUS_BAD_CHECKSUM],
                 status_count[ihc_pkg::STATUS_SHORT_HEADER]);
        if (mismatches == 0 && report_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d reports outstanding", $time, report_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
